// ----- rtl/core/qmg_pkg.sv -----
`default_nettype none
package qmg_pkg;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_FACTOR = 2'd1,
    OP_READ_Q = 2'd2,
    OP_READ_R = 2'd3
  } op_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ZERO_NORM = 2'd1;
  localparam logic [1:0] STAT_COLS_WIDE = 2'd2;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 4'd1;

  localparam logic [CFG_DATA_W-1:0] CFG_RESET = 5'd16;

  localparam int WORD_W = 32;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD,
    S_FCHK,
    S_ZERO,
    S_SQ_RD,
    S_SQ_MUL,
    S_SQ_ACC,
    S_SQ_GO,
    S_SQ_WAIT,
    S_NORM_RD,
    S_NORM_GO,
    S_NORM_WAIT,
    S_NORM_WR,
    S_NEXT_N,
    S_DOT_RD,
    S_DOT_MUL,
    S_DOT_ACC,
    S_DOT_WR,
    S_UPD_RD,
    S_UPD_MUL,
    S_UPD_WR,
    S_NEXT_C,
    S_DONE
  } state_t;

  function automatic logic [63:0] sat_add_u64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_add_s64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] q32_to_q16(input logic signed [63:0] v);
    if ((v[63:47] == '0) || (v[63:47] == '1)) begin
      return v[47:16];
    end
    return v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/qmg_if.sv -----
`default_nettype none
interface qmg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [3:0]         row;
  logic [3:0]         col;
  logic signed [23:0] element;
  modport source (output valid, operation, row, col, element, input ready);
  modport sink (input valid, operation, row, col, element, output ready);
endinterface

interface qmg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;
  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

interface qmg_cfg_if;
  import qmg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/qr_modified_gram_schmidt_unit.sv -----
`default_nettype none
// Reduced QR factorization by modified Gram-Schmidt in Q16.16 fixed point.
// Input items arrive on in_bus: write an element, factor, read Q or read R.
// Every item returns exactly one item on out_bus with a value and a status.
// Configuration writes on cfg_bus set the rows and columns in use; the port
// is always ready and must only be written while the block is idle.
// A write is answered from the idle state; a read goes by way of S_RD, as
// the matrix memories have a registered read port. A factor runs a sequencer
// over the memories: per column the sum of squares, the square root unit, the
// radix-2 divider and the entry of the Q column into the cell chain, then per
// later column the dot product and update, while the chain of cells rotates Q.
// Reset clears the control state, the configuration (16 by 16) and the last
// status; the matrix memories are not cleared and must be written first.
// While the receiver stalls the result is held and no new item is taken.
module qr_modified_gram_schmidt_unit #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  qmg_in_if.sink    in_bus,
  qmg_out_if.source out_bus,
  qmg_cfg_if.sink   cfg_bus
);
  import qmg_pkg::*;

  localparam int WDEPTH = MAX_ROWS * MAX_COLS;
  localparam int RDEPTH = MAX_COLS * MAX_COLS;
  localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int RAW = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);

  state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] rows_cfg_r, rows_cfg_nxt;
  logic [CFG_DATA_W-1:0] cols_cfg_r, cols_cfg_nxt;
  logic [RCW-1:0]        nr;
  logic [CCW-1:0]        nc;

  logic [CCW-1:0]        c_r, c_nxt;
  logic [CCW-1:0]        n_r, n_nxt;
  logic [RCW-1:0]        r_r, r_nxt;
  logic [63:0]           sum_r, sum_nxt;
  logic signed [63:0]    acc_r, acc_nxt;
  logic signed [63:0]    prod_r;
  logic signed [31:0]    mul_a, mul_b;
  logic [31:0]           norm_r, norm_nxt;
  logic [31:0]           q_r, q_nxt;
  logic [31:0]           rv_r, rv_nxt;
  logic [31:0]           a_r, a_nxt;
  logic [1:0]            st_r, st_nxt;
  logic [1:0]            last_st_r, last_st_nxt;
  logic                  rd_q_r, rd_q_nxt;
  logic                  rd_ok_r, rd_ok_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_value_r, out_value_nxt;
  logic [1:0]            out_status_r, out_status_nxt;

  logic                  in_acc;
  logic                  r_last;
  logic                  r_in_use;
  logic                  in_q_ok;
  logic                  in_r_ok;
  logic [WAW-1:0]        in_waddr;
  logic [RAW-1:0]        in_raddr;

  logic                  w_we;
  logic [WAW-1:0]        w_waddr, w_raddr;
  logic [31:0]           w_wdata, w_rdata;
  logic                  r_we;
  logic [RAW-1:0]        r_waddr, r_raddr;
  logic [31:0]           r_wdata, r_rdata;

  logic                  sq_start, sq_done;
  logic [31:0]           sq_root;
  logic [31:0]           sq_norm;
  logic                  dv_start, dv_done;
  logic [31:0]           dv_quot;

  logic                  chain_shift;
  logic                  chain_load;
  logic [31:0]           chain_tail;
  logic [31:0]           cell_q [MAX_ROWS];
  logic [31:0]           head;
  logic signed [31:0]    upd_val;
  logic signed [31:0]    dot_val;

  always_comb begin
    nr = RCW'(rows_cfg_r);
    if (rows_cfg_r == '0) begin
      nr = RCW'(1);
    end else if (int'(rows_cfg_r) > MAX_ROWS) begin
      nr = RCW'(MAX_ROWS);
    end
    nc = CCW'(cols_cfg_r);
    if (cols_cfg_r == '0) begin
      nc = CCW'(1);
    end else if (int'(cols_cfg_r) > MAX_COLS) begin
      nc = CCW'(MAX_COLS);
    end
  end

  assign in_bus.ready  = (state_r == S_IDLE) && (!out_valid_r || out_bus.ready);
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;
  assign in_q_ok  = (int'(in_bus.row) < MAX_ROWS) && (int'(in_bus.col) < MAX_COLS);
  assign in_r_ok  = (int'(in_bus.row) < MAX_COLS) && (int'(in_bus.col) < MAX_COLS);
  assign in_waddr = WAW'(int'(in_bus.row) * MAX_COLS + int'(in_bus.col));
  assign in_raddr = RAW'(int'(in_bus.row) * MAX_COLS + int'(in_bus.col));
  assign r_last   = (int'(r_r) == MAX_ROWS - 1);
  assign r_in_use = (r_r < nr);
  assign sq_norm  = sq_root[31] ? 32'h7FFF_FFFF : sq_root;
  assign head     = cell_q[0];
  assign upd_val  = q32_to_q16({{16{a_r[31]}}, a_r, 16'd0} - prod_r);
  assign dot_val  = q32_to_q16(acc_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_bus.operation))
            OP_WRITE:  state_nxt = S_IDLE;
            OP_FACTOR: state_nxt = S_FCHK;
            default:   state_nxt = S_RD;
          endcase
        end
      end
      S_RD:        state_nxt = S_IDLE;
      S_FCHK:      state_nxt = (int'(nc) > int'(nr)) ? S_DONE : S_ZERO;
      S_ZERO:      state_nxt = (c_r == nc) ? S_SQ_RD : S_ZERO;
      S_SQ_RD:     state_nxt = S_SQ_MUL;
      S_SQ_MUL:    state_nxt = S_SQ_ACC;
      S_SQ_ACC:    state_nxt = (r_r + RCW'(1) == nr) ? S_SQ_GO : S_SQ_RD;
      S_SQ_GO:     state_nxt = S_SQ_WAIT;
      S_SQ_WAIT:   state_nxt = sq_done ? S_NORM_RD : S_SQ_WAIT;
      S_NORM_RD: begin
        if (r_in_use) begin
          state_nxt = S_NORM_GO;
        end else if (r_last) begin
          state_nxt = S_NEXT_N;
        end
      end
      S_NORM_GO:   state_nxt = (norm_r == '0) ? S_NORM_WR : S_NORM_WAIT;
      S_NORM_WAIT: state_nxt = dv_done ? S_NORM_WR : S_NORM_WAIT;
      S_NORM_WR:   state_nxt = r_last ? S_NEXT_N : S_NORM_RD;
      S_NEXT_N:    state_nxt = (int'(n_r) + 1 < int'(nc)) ? S_DOT_RD : S_NEXT_C;
      S_DOT_RD: begin
        if (r_in_use) begin
          state_nxt = S_DOT_MUL;
        end else if (r_last) begin
          state_nxt = S_DOT_WR;
        end
      end
      S_DOT_MUL:   state_nxt = S_DOT_ACC;
      S_DOT_ACC:   state_nxt = r_last ? S_DOT_WR : S_DOT_RD;
      S_DOT_WR:    state_nxt = S_UPD_RD;
      S_UPD_RD: begin
        if (r_in_use) begin
          state_nxt = S_UPD_MUL;
        end else if (r_last) begin
          state_nxt = S_NEXT_N;
        end
      end
      S_UPD_MUL:   state_nxt = S_UPD_WR;
      S_UPD_WR:    state_nxt = r_last ? S_NEXT_N : S_UPD_RD;
      S_NEXT_C:    state_nxt = (int'(c_r) + 1 == int'(nc)) ? S_DONE : S_SQ_RD;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rows_cfg_nxt   = rows_cfg_r;
    cols_cfg_nxt   = cols_cfg_r;
    c_nxt          = c_r;
    n_nxt          = n_r;
    r_nxt          = r_r;
    sum_nxt        = sum_r;
    acc_nxt        = acc_r;
    norm_nxt       = norm_r;
    q_nxt          = q_r;
    rv_nxt         = rv_r;
    a_nxt          = a_r;
    st_nxt         = st_r;
    last_st_nxt    = last_st_r;
    rd_q_nxt       = rd_q_r;
    rd_ok_nxt      = rd_ok_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    w_we           = 1'b0;
    w_waddr        = WAW'(int'(r_r) * MAX_COLS + int'(c_r));
    w_wdata        = q_r;
    w_raddr        = WAW'(int'(r_r) * MAX_COLS + int'(c_r));
    r_we           = 1'b0;
    r_waddr        = RAW'(int'(c_r) * MAX_COLS + int'(n_r));
    r_wdata        = '0;
    r_raddr        = in_raddr;
    sq_start       = 1'b0;
    dv_start       = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    chain_shift    = 1'b0;
    chain_load     = 1'b0;
    chain_tail     = '0;

    if (cfg_bus.valid) begin
      if (cfg_bus.index == REG_ROWS) begin
        rows_cfg_nxt = cfg_bus.data;
      end else if (cfg_bus.index == REG_COLS) begin
        cols_cfg_nxt = cfg_bus.data;
      end
    end

    case (state_r)
      S_IDLE: begin
        w_raddr = in_waddr;
        if (in_acc) begin
          case (op_t'(in_bus.operation))
            OP_WRITE: begin
              w_we           = in_q_ok;
              w_waddr        = in_waddr;
              w_wdata        = 32'(in_bus.element);
              out_valid_nxt  = 1'b1;
              out_value_nxt  = '0;
              out_status_nxt = last_st_r;
            end
            OP_FACTOR: begin
              c_nxt = '0;
              n_nxt = '0;
            end
            OP_READ_Q: begin
              rd_q_nxt  = 1'b1;
              rd_ok_nxt = in_q_ok;
            end
            default: begin
              rd_q_nxt  = 1'b0;
              rd_ok_nxt = in_r_ok;
            end
          endcase
        end
      end
      S_RD: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = !rd_ok_r ? '0 : (rd_q_r ? w_rdata : r_rdata);
        out_status_nxt = last_st_r;
      end
      S_FCHK: begin
        st_nxt = (int'(nc) > int'(nr)) ? STAT_COLS_WIDE : STAT_OK;
      end
      S_ZERO: begin
        if (c_r == nc) begin
          c_nxt   = '0;
          r_nxt   = '0;
          sum_nxt = '0;
        end else if (n_r < c_r) begin
          r_we  = 1'b1;
          n_nxt = n_r + CCW'(1);
        end else begin
          c_nxt = c_r + CCW'(1);
          n_nxt = '0;
        end
      end
      S_SQ_MUL: begin
        mul_a = w_rdata;
        mul_b = w_rdata;
      end
      S_SQ_ACC: begin
        sum_nxt = sat_add_u64(sum_r, prod_r);
        r_nxt   = r_r + RCW'(1);
      end
      S_SQ_GO: begin
        sq_start = 1'b1;
      end
      S_SQ_WAIT: begin
        if (sq_done) begin
          norm_nxt = sq_norm;
          r_we     = 1'b1;
          r_waddr  = RAW'(int'(c_r) * MAX_COLS + int'(c_r));
          r_wdata  = sq_norm;
          r_nxt    = '0;
          if (sq_norm == '0) begin
            st_nxt = STAT_ZERO_NORM;
          end
        end
      end
      S_NORM_RD: begin
        if (!r_in_use) begin
          chain_shift = 1'b1;
          chain_load  = 1'b1;
          chain_tail  = '0;
          if (r_last) begin
            n_nxt = c_r;
          end else begin
            r_nxt = r_r + RCW'(1);
          end
        end
      end
      S_NORM_GO: begin
        if (norm_r == '0) begin
          q_nxt = '0;
        end else begin
          dv_start = 1'b1;
        end
      end
      S_NORM_WAIT: begin
        if (dv_done) begin
          q_nxt = dv_quot;
        end
      end
      S_NORM_WR: begin
        w_we        = 1'b1;
        w_wdata     = q_r;
        chain_shift = 1'b1;
        chain_load  = 1'b1;
        chain_tail  = q_r;
        if (r_last) begin
          n_nxt = c_r;
        end else begin
          r_nxt = r_r + RCW'(1);
        end
      end
      S_NEXT_N: begin
        if (int'(n_r) + 1 < int'(nc)) begin
          n_nxt   = n_r + CCW'(1);
          r_nxt   = '0;
          acc_nxt = '0;
        end
      end
      S_DOT_RD: begin
        w_raddr = WAW'(int'(r_r) * MAX_COLS + int'(n_r));
        if (!r_in_use) begin
          chain_shift = 1'b1;
          if (!r_last) begin
            r_nxt = r_r + RCW'(1);
          end
        end
      end
      S_DOT_MUL: begin
        mul_a = head;
        mul_b = w_rdata;
      end
      S_DOT_ACC: begin
        acc_nxt     = sat_add_s64(acc_r, prod_r);
        chain_shift = 1'b1;
        if (!r_last) begin
          r_nxt = r_r + RCW'(1);
        end
      end
      S_DOT_WR: begin
        rv_nxt  = dot_val;
        r_we    = 1'b1;
        r_wdata = dot_val;
        r_nxt   = '0;
      end
      S_UPD_RD: begin
        w_raddr = WAW'(int'(r_r) * MAX_COLS + int'(n_r));
        if (!r_in_use) begin
          chain_shift = 1'b1;
          if (!r_last) begin
            r_nxt = r_r + RCW'(1);
          end
        end
      end
      S_UPD_MUL: begin
        mul_a = rv_r;
        mul_b = head;
        a_nxt = w_rdata;
      end
      S_UPD_WR: begin
        w_we        = 1'b1;
        w_waddr     = WAW'(int'(r_r) * MAX_COLS + int'(n_r));
        w_wdata     = upd_val;
        chain_shift = 1'b1;
        if (!r_last) begin
          r_nxt = r_r + RCW'(1);
        end
      end
      S_NEXT_C: begin
        if (int'(c_r) + 1 != int'(nc)) begin
          c_nxt   = c_r + CCW'(1);
          r_nxt   = '0;
          sum_nxt = '0;
        end
      end
      S_DONE: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = '0;
        out_status_nxt = st_r;
        last_st_nxt    = st_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_cfg_r  <= CFG_RESET;
      cols_cfg_r  <= CFG_RESET;
      last_st_r   <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_cfg_r  <= rows_cfg_nxt;
      cols_cfg_r  <= cols_cfg_nxt;
      last_st_r   <= last_st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    c_r          <= c_nxt;
    n_r          <= n_nxt;
    r_r          <= r_nxt;
    sum_r        <= sum_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= mul_a * mul_b;
    norm_r       <= norm_nxt;
    q_r          <= q_nxt;
    rv_r         <= rv_nxt;
    a_r          <= a_nxt;
    st_r         <= st_nxt;
    rd_q_r       <= rd_q_nxt;
    rd_ok_r      <= rd_ok_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_bus.valid  = out_valid_r;
  assign out_bus.value  = out_value_r;
  assign out_bus.status = out_status_r;

  qmg_ram #(.WIDTH(WORD_W), .DEPTH(WDEPTH)) u_work_ram (
    .clk  (clk),
    .we   (w_we),
    .waddr(w_waddr),
    .wdata(w_wdata),
    .raddr(w_raddr),
    .rdata(w_rdata)
  );

  qmg_ram #(.WIDTH(WORD_W), .DEPTH(RDEPTH)) u_upper_ram (
    .clk  (clk),
    .we   (r_we),
    .waddr(r_waddr),
    .wdata(r_wdata),
    .raddr(r_raddr),
    .rdata(r_rdata)
  );

  qmg_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .x    (sum_r),
    .done (sq_done),
    .root (sq_root)
  );

  qmg_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(dv_start),
    .x    (w_rdata),
    .d    (norm_r[30:0]),
    .done (dv_done),
    .quot (dv_quot)
  );

  // The Q column of the current pivot circulates through the chain; the head
  // cell holds the element of the row being processed during the dot product and update.
  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_chain
    logic [31:0] d_in;
    if (i == MAX_ROWS - 1) begin : g_tail
      assign d_in = chain_load ? chain_tail : cell_q[0];
    end else begin : g_mid
      assign d_in = cell_q[i+1];
    end
    qmg_cell u_cell (
      .clk  (clk),
      .shift(chain_shift),
      .d_in (d_in),
      .q_out(cell_q[i])
    );
  end
endmodule
`default_nettype wire

// ----- rtl/core/qmg_ram.sv -----
`default_nettype none
module qmg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/qmg_cell.sv -----
`default_nettype none
module qmg_cell (
  input  wire logic        clk,
  input  wire logic        shift,
  input  wire logic [31:0] d_in,
  output logic      [31:0] q_out
);
  logic [31:0] value_r;
  logic [31:0] value_nxt;

  always_comb begin
    value_nxt = shift ? d_in : value_r;
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign q_out = value_r;
endmodule
`default_nettype wire

// ----- rtl/core/qmg_sqrt.sv -----
`default_nettype none
module qmg_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] x,
  output logic             done,
  output logic      [31:0] root
);
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;

  always_comb begin
    trial    = {1'b0, res_r} + {1'b0, bit_r};
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = x;
      res_nxt  = '0;
      bit_nxt  = 64'd1 << 62;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_nxt = rem_r - trial[63:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[31:0];
endmodule
`default_nettype wire

// ----- rtl/core/qmg_div.sv -----
`default_nettype none
module qmg_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] x,
  input  wire logic        [30:0] d,
  output logic                    done,
  output logic signed [31:0]      quot
);
  localparam int STEPS = 48;

  logic [47:0] dvd_r, dvd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] d_r, d_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [31:0] mag;

  always_comb begin
    mag      = x[31] ? (~x + 32'd1) : x;
    trial    = {rem_r, dvd_r[47]};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = {mag, 16'd0};
      rem_nxt  = '0;
      d_nxt    = d;
      neg_nxt  = x[31];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {2'b00, d_r}) begin
        rem_nxt = 32'(trial - {2'b00, d_r});
        dvd_nxt = {dvd_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        dvd_nxt = {dvd_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (int'(cnt_r) == STEPS - 1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    if (!neg_r) begin
      quot = (dvd_r[47:31] != '0) ? 32'h7FFF_FFFF : dvd_r[31:0];
    end else if ((dvd_r[47:32] != '0) || (dvd_r[31] && (dvd_r[30:0] != '0))) begin
      quot = 32'h8000_0000;
    end else begin
      quot = ~dvd_r[31:0] + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
endmodule
`default_nettype wire

// ----- rtl/core/qmg_checker.sv -----
`default_nettype none
module qmg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_operation,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic [1:0]  out_status
);
  import qmg_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_WRITE) |=> out_valid && (out_value == '0))
    else $error("write item gave no immediate zero result");

  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while result slot is blocked");
endmodule

bind qr_modified_gram_schmidt_unit qmg_checker u_qmg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .in_operation(in_bus.operation),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_value   (out_bus.value),
  .out_status  (out_bus.status)
);
`default_nettype wire
